// ----- hdl/rbs_pkg.sv -----
// rbs_pkg: shared types, register indexes and IEEE single precision helpers for the slab test
package rbs_pkg;

	localparam int LANE_STAGES = 7;
	localparam int PIPE_STAGES = 9;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
	localparam logic [31:0] FP_INF    = 32'h7F80_0000;
	localparam logic [31:0] FP_ZERO   = 32'h0000_0000;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_DIR_X    = 3'd3;
	localparam logic [2:0] CFG_DIR_Y    = 3'd4;
	localparam logic [2:0] CFG_DIR_Z    = 3'd5;
	localparam logic [2:0] CFG_T_START  = 3'd6;
	localparam logic [2:0] CFG_T_LIMIT  = 3'd7;

	typedef logic [LANE_STAGES-1:0] lane_en_t;

	typedef enum logic [1:0] {
		RCP_IDLE,
		RCP_DIV,
		RCP_NORM,
		RCP_ROUND
	} rcp_state_t;

	// unnormalised operand: bit 50 of m weighs 2^(eb-127)
	typedef struct packed {
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic signed [10:0] eb;
		logic [51:0]        m;
	} norm_in_t;

	// normalised operand: bit 51 of n weighs 2^(e-127), bit 0 holds sticky
	typedef struct packed {
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic signed [10:0] e;
		logic [51:0]        n;
	} rnd_in_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	function automatic logic [7:0] exp_of(input logic [31:0] x);
		return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
	endfunction

	function automatic logic [23:0] man_of(input logic [31:0] x);
		return {x[30:23] != 8'd0, x[22:0]};
	endfunction

	function automatic logic [5:0] lzc52(input logic [51:0] m);
		logic [5:0] n;
		n = 6'd52;
		for (int i = 0; i < 52; i++) begin
			if (m[i]) n = 6'(51 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc24(input logic [23:0] m);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] x);
		return is_nan(x) ? CANON_NAN : x;
	endfunction

	// ordered a > b; false with any nan, zeros compare equal
	function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		if (is_nan(a) || is_nan(b)) return 1'b0;
		if (is_zero(a) && is_zero(b)) return 1'b0;
		return ka > kb;
	endfunction

	// a - b: alignment and exact add
	function automatic norm_in_t fp_sub_pre(input logic [31:0] a, input logic [31:0] b);
		norm_in_t    r;
		logic        sa;
		logic        sb;
		logic        sl;
		logic        ss;
		logic [7:0]  el;
		logic [7:0]  es;
		logic [7:0]  d;
		logic [23:0] ml;
		logic [23:0] ms;
		logic [51:0] xl;
		logic [51:0] xs;
		logic [51:0] sum;
		sa = a[31];
		sb = ~b[31];
		r.spec = 1'b0;
		r.spec_val = CANON_NAN;
		r.sign = 1'b0;
		r.eb = 11'sd0;
		r.m = 52'd0;
		if (is_nan(a) || is_nan(b)) begin
			r.spec = 1'b1;
		end else if (is_inf(a) && is_inf(b) && (sa != sb)) begin
			r.spec = 1'b1;
		end else if (is_inf(a)) begin
			r.spec = 1'b1;
			r.spec_val = {sa, FP_INF[30:0]};
		end else if (is_inf(b)) begin
			r.spec = 1'b1;
			r.spec_val = {sb, FP_INF[30:0]};
		end else begin
			if (b[30:0] > a[30:0]) begin
				sl = sb; el = exp_of(b); ml = man_of(b);
				ss = sa; es = exp_of(a); ms = man_of(a);
			end else begin
				sl = sa; el = exp_of(a); ml = man_of(a);
				ss = sb; es = exp_of(b); ms = man_of(b);
			end
			d = el - es;
			xl = {1'b0, ml, 27'd0};
			xs = (d <= 8'd27) ? ({1'b0, ms, 27'd0} >> d) : {51'd0, |ms};
			sum = (sl == ss) ? (xl + xs) : (xl - xs);
			r.m = sum;
			r.eb = $signed({3'b000, el});
			r.sign = ((sum == 52'd0) && (sl != ss)) ? 1'b0 : sl;
		end
		return r;
	endfunction

	// a * b: specials and exact mantissa product
	function automatic norm_in_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
		norm_in_t    r;
		logic        s;
		logic [47:0] p;
		s = a[31] ^ b[31];
		p = man_of(a) * man_of(b);
		r.spec = 1'b0;
		r.spec_val = CANON_NAN;
		r.sign = s;
		r.m = {p, 4'd0};
		r.eb = $signed({3'b000, exp_of(a)}) + $signed({3'b000, exp_of(b)}) - 11'sd127;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) ||
				(is_zero(a) && is_inf(b))) begin
			r.spec = 1'b1;
		end else if (is_inf(a) || is_inf(b)) begin
			r.spec = 1'b1;
			r.spec_val = {s, FP_INF[30:0]};
		end
		return r;
	endfunction

	// leading-one alignment, subnormal clamp with sticky
	function automatic rnd_in_t fp_norm(input norm_in_t x);
		rnd_in_t            r;
		logic [5:0]         lz;
		logic signed [10:0] ex;
		logic [10:0]        rs;
		logic [51:0]        lost;
		lz = lzc52(x.m);
		ex = x.eb + 11'sd1 - $signed({5'd0, lz});
		rs = 11'(-x.eb);
		lost = x.m & ~({52{1'b1}} << rs);
		r.spec = x.spec;
		r.spec_val = x.spec_val;
		r.sign = x.sign;
		r.e = 11'sd1;
		r.n = 52'd0;
		if (!x.spec && (x.m == 52'd0)) begin
			r.spec = 1'b1;
			r.spec_val = {x.sign, 31'd0};
		end else if (ex >= 11'sd1) begin
			r.n = x.m << lz;
			r.e = ex;
		end else if (x.eb >= 11'sd0) begin
			r.n = x.m << x.eb[5:0];
		end else begin
			r.n = (x.m >> rs) | {51'd0, |lost};
		end
		return r;
	endfunction

	// round to nearest even and pack
	function automatic logic [31:0] fp_round(input rnd_in_t x);
		logic [23:0]        mt;
		logic               g;
		logic               st;
		logic               up;
		logic [24:0]        s;
		logic [23:0]        mf;
		logic signed [10:0] e2;
		mt = x.n[51:28];
		g = x.n[27];
		st = |x.n[26:0];
		up = g & (st | mt[0]);
		s = {1'b0, mt} + {24'd0, up};
		if (s[24]) begin
			mf = s[24:1];
			e2 = x.e + 11'sd1;
		end else begin
			mf = s[23:0];
			e2 = x.e;
		end
		if (x.spec) return x.spec_val;
		if (e2 >= 11'sd255) return {x.sign, FP_INF[30:0]};
		return {x.sign, mf[23] ? e2[7:0] : 8'h00, mf[22:0]};
	endfunction

endpackage

// ----- hdl/rbs_recip.sv -----
// rbs_recip: sequential reciprocal of the three direction components, one quotient bit per cycle
module rbs_recip (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       dir_wr,
	input  logic [2:0][31:0] dir,
	output logic             busy,
	output logic [2:0][31:0] inv
);

	rbs_pkg::rcp_state_t state_q, state_nxt;

	logic [2:0]         pend_q;
	logic [1:0]         sel_q;
	logic [1:0]         pick;
	logic               start;
	logic [23:0]        m_q;
	logic [25:0]        r_q;
	logic [26:0]        q_q;
	logic [4:0]         cnt_q;
	logic signed [10:0] eb_q;
	logic               sign_q;
	logic               spec_q;
	logic [31:0]        specv_q;
	rbs_pkg::rnd_in_t   nrm_q;
	rbs_pkg::norm_in_t  div_out;
	logic [2:0][31:0]   inv_q;

	logic [31:0]        d;
	logic [4:0]         lz;
	logic [23:0]        m_ld;
	logic signed [10:0] e_eff;

	assign pick  = pend_q[0] ? 2'd0 : (pend_q[1] ? 2'd1 : 2'd2);
	assign start = (state_q == rbs_pkg::RCP_IDLE) && (pend_q != 3'd0);
	assign busy  = (state_q != rbs_pkg::RCP_IDLE) || (pend_q != 3'd0) || (dir_wr != 3'd0);
	assign inv   = inv_q;

	always_comb begin
		d = dir[pick];
		lz = rbs_pkg::lzc24({1'b0, d[22:0]});
		if (d[30:23] == 8'd0) begin
			m_ld = {1'b0, d[22:0]} << lz;
			e_eff = 11'sd1 - $signed({6'd0, lz});
		end else begin
			m_ld = {1'b1, d[22:0]};
			e_eff = $signed({3'b000, d[30:23]});
		end
	end

	always_comb begin
		div_out.spec = spec_q;
		div_out.spec_val = specv_q;
		div_out.sign = sign_q;
		div_out.eb = eb_q;
		div_out.m = {q_q, r_q != 26'd0, 24'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbs_pkg::RCP_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rbs_pkg::RCP_IDLE:  if (start) state_nxt = rbs_pkg::RCP_DIV;
			rbs_pkg::RCP_DIV:   if (cnt_q == 5'd26) state_nxt = rbs_pkg::RCP_NORM;
			rbs_pkg::RCP_NORM:  state_nxt = rbs_pkg::RCP_ROUND;
			rbs_pkg::RCP_ROUND: state_nxt = rbs_pkg::RCP_IDLE;
			default:            state_nxt = rbs_pkg::RCP_IDLE;
		endcase
	end

	// pending requests and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
			for (int i = 0; i < 3; i++) inv_q[i] <= rbs_pkg::FP_ONE;
		end else begin
			pend_q <= (pend_q & ~(start ? (3'd1 << pick) : 3'd0)) | dir_wr;
			if (state_q == rbs_pkg::RCP_ROUND) inv_q[sel_q] <= rbs_pkg::fp_round(nrm_q);
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sel_q <= pick;
			m_q <= m_ld;
			r_q <= 26'h080_0000;
			q_q <= 27'd0;
			cnt_q <= 5'd0;
			eb_q <= 11'sd253 - e_eff;
			sign_q <= d[31];
			spec_q <= rbs_pkg::is_nan(d) || rbs_pkg::is_zero(d) || rbs_pkg::is_inf(d);
			if (rbs_pkg::is_nan(d)) specv_q <= rbs_pkg::CANON_NAN;
			else if (rbs_pkg::is_zero(d)) specv_q <= {d[31], rbs_pkg::FP_INF[30:0]};
			else specv_q <= {d[31], 31'd0};
		end else if (state_q == rbs_pkg::RCP_DIV) begin
			cnt_q <= cnt_q + 5'd1;
			if (r_q >= {2'b00, m_q}) begin
				r_q <= (r_q - {2'b00, m_q}) << 1;
				q_q <= {q_q[25:0], 1'b1};
			end else begin
				r_q <= r_q << 1;
				q_q <= {q_q[25:0], 1'b0};
			end
		end
		if (state_q == rbs_pkg::RCP_NORM) nrm_q <= rbs_pkg::fp_norm(div_out);
	end

endmodule

// ----- hdl/rbs_lane.sv -----
// rbs_lane: one slab of the test, subtract, scale by the reciprocal and order the pair
module rbs_lane (
	input  logic              clk,
	input  rbs_pkg::lane_en_t en,
	input  logic [31:0]       box_lo,
	input  logic [31:0]       box_hi,
	input  logic [31:0]       origin,
	input  logic [31:0]       inv,
	output logic [31:0]       t_near,
	output logic [31:0]       t_far
);

	rbs_pkg::norm_in_t nd_s1, fd_s1;
	rbs_pkg::rnd_in_t  nd_s2, fd_s2;
	logic [31:0]       nd_s3, fd_s3;
	rbs_pkg::norm_in_t np_s4, fp_s4;
	rbs_pkg::rnd_in_t  np_s5, fp_s5;
	logic [31:0]       tn_s6, tf_s6;
	logic [31:0]       lo_s7, hi_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			nd_s1 <= rbs_pkg::fp_sub_pre(box_lo, origin);
			fd_s1 <= rbs_pkg::fp_sub_pre(box_hi, origin);
		end
		if (en[1]) begin
			nd_s2 <= rbs_pkg::fp_norm(nd_s1);
			fd_s2 <= rbs_pkg::fp_norm(fd_s1);
		end
		if (en[2]) begin
			nd_s3 <= rbs_pkg::fp_round(nd_s2);
			fd_s3 <= rbs_pkg::fp_round(fd_s2);
		end
		if (en[3]) begin
			np_s4 <= rbs_pkg::fp_mul_pre(nd_s3, inv);
			fp_s4 <= rbs_pkg::fp_mul_pre(fd_s3, inv);
		end
		if (en[4]) begin
			np_s5 <= rbs_pkg::fp_norm(np_s4);
			fp_s5 <= rbs_pkg::fp_norm(fp_s4);
		end
		if (en[5]) begin
			tn_s6 <= rbs_pkg::fp_round(np_s5);
			tf_s6 <= rbs_pkg::fp_round(fp_s5);
		end
		if (en[6]) begin
			if (rbs_pkg::fp_gt(tn_s6, tf_s6)) begin
				lo_s7 <= tf_s6;
				hi_s7 <= tn_s6;
			end else begin
				lo_s7 <= tn_s6;
				hi_s7 <= tf_s6;
			end
		end
	end

	assign t_near = lo_s7;
	assign t_far  = hi_s7;

endmodule

// ----- hdl/ray_box_slab_test.sv -----
// ray_box_slab_test: ray against axis-aligned box slab test in IEEE single precision
//
//   channel   valid       stall       payload
//   box in    box_valid   box_stall   box_min_x..z, box_max_x..z
//   result    res_valid   res_stall   hit, t_enter, t_exit
//   config    cfg_we      -           cfg_index, cfg_data
//
// one box per cycle while box_stall is low, through a nine stage pipeline;
// stages 1-7 are the three slab lanes (subtract, normalise, round, multiply,
// normalise, round, order), 8 folds x and y, 9 folds z into the output register
// a write to a direction register starts the reciprocal sequencer, and
// box_stall is high until it is done
// reset holds the default ray; every bubble in the pipe is squeezed out, so
// a held result stalls only the stages behind it that are full
module ray_box_slab_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        box_valid,
	output logic        box_stall,
	input  logic [31:0] box_min_x,
	input  logic [31:0] box_min_y,
	input  logic [31:0] box_min_z,
	input  logic [31:0] box_max_x,
	input  logic [31:0] box_max_y,
	input  logic [31:0] box_max_z,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        hit,
	output logic [31:0] t_enter,
	output logic [31:0] t_exit
);

	localparam int NS = rbs_pkg::PIPE_STAGES;

	// configuration registers
	logic [2:0][31:0] origin_q;
	logic [2:0][31:0] dir_q;
	logic [31:0]      t_start_q;
	logic [31:0]      t_limit_q;
	logic [2:0]       dir_wr;
	logic [2:0][31:0] inv;
	logic             rcp_busy;

	// pipeline control
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic          box_acc;

	// lane results
	logic [2:0][31:0] box_lo;
	logic [2:0][31:0] box_hi;
	logic [2:0][31:0] t_near;
	logic [2:0][31:0] t_far;

	// fold stages
	logic [31:0] t0_s8, t1_s8, tnz_s8, tfz_s8;
	logic        miss_s8;
	logic        hit_s9;
	logic [31:0] t_enter_s9, t_exit_s9;
	logic [31:0] t0a, t1a, t0b, t1b, t0c, t1c;
	logic        miss_c;

	assign box_lo = {box_min_z, box_min_y, box_min_x};
	assign box_hi = {box_max_z, box_max_y, box_max_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			for (int i = 0; i < 3; i++) dir_q[i] <= rbs_pkg::FP_ONE;
			t_start_q <= rbs_pkg::FP_ZERO;
			t_limit_q <= rbs_pkg::FP_INF;
		end else if (cfg_we) begin
			case (cfg_index)
				rbs_pkg::CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				rbs_pkg::CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				rbs_pkg::CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				rbs_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data;
				rbs_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data;
				rbs_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data;
				rbs_pkg::CFG_T_START:  t_start_q <= cfg_data;
				rbs_pkg::CFG_T_LIMIT:  t_limit_q <= cfg_data;
				default:               t_limit_q <= t_limit_q;
			endcase
		end
	end

	// a direction write kicks off its reciprocal once the new value is in place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_wr <= 3'd0;
		end else begin
			dir_wr[0] <= cfg_we && (cfg_index == rbs_pkg::CFG_DIR_X);
			dir_wr[1] <= cfg_we && (cfg_index == rbs_pkg::CFG_DIR_Y);
			dir_wr[2] <= cfg_we && (cfg_index == rbs_pkg::CFG_DIR_Z);
		end
	end

	rbs_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.dir_wr (dir_wr),
		.dir    (dir_q),
		.busy   (rcp_busy),
		.inv    (inv)
	);

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || !res_stall;
		for (int k = NS - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
	end

	// hold boxes off while the first stage is blocked or a direction write is still being turned into a reciprocal
	assign box_stall = !en[0] || rcp_busy || (cfg_we && (cfg_index == rbs_pkg::CFG_DIR_X ||
		cfg_index == rbs_pkg::CFG_DIR_Y || cfg_index == rbs_pkg::CFG_DIR_Z));
	assign box_acc = box_valid && !box_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= box_acc;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rbs_lane u_lane (
			.clk    (clk),
			.en     (en[rbs_pkg::LANE_STAGES-1:0]),
			.box_lo (box_lo[g]),
			.box_hi (box_hi[g]),
			.origin (origin_q[g]),
			.inv    (inv[g]),
			.t_near (t_near[g]),
			.t_far  (t_far[g])
		);
	end

	// narrow the interval by the x and y slabs
	always_comb begin
		t0a = rbs_pkg::fp_gt(t_near[0], t_start_q) ? t_near[0] : t_start_q;
		t1a = rbs_pkg::fp_gt(t_limit_q, t_far[0]) ? t_far[0] : t_limit_q;
		t0b = rbs_pkg::fp_gt(t_near[1], t0a) ? t_near[1] : t0a;
		t1b = rbs_pkg::fp_gt(t1a, t_far[1]) ? t_far[1] : t1a;
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			t0_s8 <= t0b;
			t1_s8 <= t1b;
			miss_s8 <= rbs_pkg::fp_gt(t0a, t1a) || rbs_pkg::fp_gt(t0b, t1b);
			tnz_s8 <= t_near[2];
			tfz_s8 <= t_far[2];
		end
	end

	// z slab and the final verdict; a miss reports zero times
	always_comb begin
		t0c = rbs_pkg::fp_gt(tnz_s8, t0_s8) ? tnz_s8 : t0_s8;
		t1c = rbs_pkg::fp_gt(t1_s8, tfz_s8) ? tfz_s8 : t1_s8;
		miss_c = miss_s8 || rbs_pkg::fp_gt(t0c, t1c);
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hit_s9 <= !miss_c;
			t_enter_s9 <= miss_c ? rbs_pkg::FP_ZERO : rbs_pkg::canon(t0c);
			t_exit_s9 <= miss_c ? rbs_pkg::FP_ZERO : rbs_pkg::canon(t1c);
		end
	end

	assign res_valid = vld_q[NS-1];
	assign hit       = hit_s9;
	assign t_enter   = t_enter_s9;
	assign t_exit    = t_exit_s9;

endmodule

// ----- hdl/rbs_checker.sv -----
// rbs_checker: port-level checks on the slab test, bound to the top level
module rbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        box_valid,
	input logic        box_stall,
	input logic [31:0] box_min_x,
	input logic [31:0] box_min_y,
	input logic [31:0] box_min_z,
	input logic [31:0] box_max_x,
	input logic [31:0] box_max_y,
	input logic [31:0] box_max_z,
	input logic        res_valid,
	input logic        res_stall,
	input logic        hit,
	input logic [31:0] t_enter,
	input logic [31:0] t_exit
);

	// a stalled box transaction stays offered with the same payload
	a_box_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_stall |=> box_valid && $stable(box_min_x) && $stable(box_min_y) &&
			$stable(box_min_z) && $stable(box_max_x) && $stable(box_max_y) &&
			$stable(box_max_z))
		else $error("box transaction changed while stalled");

	// a stalled result transaction stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result transaction keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(hit) && $stable(t_enter) && $stable(t_exit))
		else $error("result payload changed while stalled");

	// a miss carries zero times
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit |-> t_enter == 32'd0 && t_exit == 32'd0)
		else $error("miss with non-zero times");

	// a nan t_enter is always the canonical one
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && t_enter[30:23] == 8'hFF |->
			t_enter[22:0] == 23'd0 || t_enter == rbs_pkg::CANON_NAN)
		else $error("non-canonical nan on t_enter");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (.*);

// ----- dv/tb.sv -----
// tb: self-checking testbench for the ray against axis-aligned box slab test
`timescale 1ns / 100ps

module tb;

	localparam int N_PHASES     = 8;
	localparam int BOXES_PHASE  = 235;
	localparam int SETTLE       = rbs_pkg::PIPE_STAGES + 6;
	localparam logic [31:0] FP_MAX   = 32'h7F7F_FFFF;
	localparam logic [31:0] FP_MINSUB = 32'h0000_0001;
	localparam logic [31:0] FP_MAXSUB = 32'h007F_FFFF;
	localparam logic [31:0] FP_SIGN  = 32'h8000_0000;
	localparam logic [31:0] FP_SNAN  = 32'h7F80_0001;

	typedef struct {
		logic [31:0] lo [3];
		logic [31:0] hi [3];
	} box_t;

	typedef struct {
		logic        hit;
		logic [31:0] t_enter;
		logic [31:0] t_exit;
	} slab_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        box_valid;
	logic        box_stall;
	logic [31:0] box_min_x, box_min_y, box_min_z;
	logic [31:0] box_max_x, box_max_y, box_max_z;
	logic        res_valid;
	logic        res_stall;
	logic        hit;
	logic [31:0] t_enter;
	logic [31:0] t_exit;

	// ray registers as the block should hold them
	logic [31:0] ray_reg [8];

	box_t      boxes_pending [$];
	slab_res_t hits_expected [$];
	int        errors;
	bit        quiet;
	int        send_gap;
	int        stall_len;

	ray_box_slab_test uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.box_valid(box_valid), .box_stall(box_stall),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.res_valid(res_valid), .res_stall(res_stall),
		.hit(hit), .t_enter(t_enter), .t_exit(t_exit)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// single precision bit pattern widened exactly into a double
	function automatic real sp_to_real(input logic [31:0] f);
		logic [63:0] d;
		if (f[30:23] == 8'hFF) begin
			d = {f[31], 11'h7FF, (f[22:0] != 23'd0) ? 52'h8_0000_0000_0000 : 52'd0};
		end else if (f[30:23] == 8'd0) begin
			// subnormal: integer times 2^-149, exact in double
			return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) *
				$bitstoreal(64'h36A0_0000_0000_0000);
		end else begin
			d = {f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0};
		end
		return $bitstoreal(d);
	endfunction

	// round a double to single, nearest even, subnormals kept, nan made canonical
	// a single op done in double and rounded once more is still correctly rounded
	function automatic logic [31:0] real_to_sp(input real x);
		logic [63:0] d;
		logic [63:0] m53;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		int          e;
		int          sh;
		d = $realtobits(x);
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 52'd0) ? rbs_pkg::CANON_NAN :
				{d[63], rbs_pkg::FP_INF[30:0]};
		if (d[62:0] == 63'd0)
			return {d[63], 31'd0};
		e = int'(d[62:52]) - 1023;
		m53 = {11'd0, 1'b1, d[51:0]};
		sh = (e >= -126) ? 29 : 29 + (-126 - e);
		if (sh > 60) sh = 60;
		kept = m53 >> sh;
		rem = m53 & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
		if (e >= -126) begin
			if (kept[24]) begin
				kept = kept >> 1;
				e = e + 1;
			end
			if (e > 127) return {d[63], rbs_pkg::FP_INF[30:0]};
			return {d[63], 8'(e + 127), kept[22:0]};
		end
		// subnormal; a carry into bit 23 lands on the smallest normal
		return {d[63], kept[30:0]};
	endfunction

	function automatic real sp_round(input real x);
		return sp_to_real(real_to_sp(x));
	endfunction

	// slab test of one box against the held ray
	function automatic slab_res_t slab_intersect(input box_t b);
		slab_res_t r;
		real       t0;
		real       t1;
		real       inv;
		real       org;
		real       tn;
		real       tf;
		real       sw;
		logic [31:0] dv;
		bit        gone;
		t0 = sp_to_real(ray_reg[rbs_pkg::CFG_T_START]);
		t1 = sp_to_real(ray_reg[rbs_pkg::CFG_T_LIMIT]);
		gone = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (!gone) begin
				dv = ray_reg[rbs_pkg::CFG_DIR_X + a];
				// a zero direction gives an infinity with the sign of the zero
				if (dv[30:0] == 31'd0)
					inv = sp_to_real({dv[31], rbs_pkg::FP_INF[30:0]});
				else
					inv = sp_round(1.0 / sp_to_real(dv));
				org = sp_to_real(ray_reg[rbs_pkg::CFG_ORIGIN_X + a]);
				tn = sp_round(sp_round(sp_to_real(b.lo[a]) - org) * inv);
				tf = sp_round(sp_round(sp_to_real(b.hi[a]) - org) * inv);
				if (tn > tf) begin
					sw = tn;
					tn = tf;
					tf = sw;
				end
				// nan compares false everywhere, so these follow the formulas literally
				t0 = (tn > t0) ? tn : t0;
				t1 = (tf < t1) ? tf : t1;
				gone = (t0 > t1);
			end
		end
		r.hit = !gone;
		r.t_enter = gone ? rbs_pkg::FP_ZERO : real_to_sp(t0);
		r.t_exit  = gone ? rbs_pkg::FP_ZERO : real_to_sp(t1);
		return r;
	endfunction

	function automatic real rand_real(input int span);
		return (real'($urandom_range(0, 2 * span * 1000)) - real'(span * 1000)) / 1000.0;
	endfunction

	// odd values: specials, subnormals, extremes, or raw bits
	function automatic logic [31:0] odd_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = rbs_pkg::FP_ZERO;
			1: v = rbs_pkg::FP_INF;
			2: v = FP_SNAN;
			3: v = FP_MAX;
			4: v = FP_MINSUB;
			5: v = FP_MAXSUB;
			6: v = rbs_pkg::CANON_NAN;
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 1)) v = v ^ FP_SIGN;
		return v;
	endfunction

	// mostly boxes near the ray origin so that hits and near misses both occur
	function automatic box_t random_box();
		box_t b;
		real  o;
		int   mode;
		mode = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			o = sp_to_real(ray_reg[rbs_pkg::CFG_ORIGIN_X + a]);
			if (mode < 7) begin
				b.lo[a] = real_to_sp(o + rand_real(6));
				b.hi[a] = real_to_sp(o + rand_real(6));
				if (mode < 4 && $urandom_range(0, 2) != 0) begin
					b.lo[a] = real_to_sp(o - real'($urandom_range(1, 4000)) / 1000.0);
					b.hi[a] = real_to_sp(o + real'($urandom_range(1, 4000)) / 1000.0);
				end
			end else if (mode < 9) begin
				b.lo[a] = $urandom;
				b.hi[a] = $urandom;
			end else begin
				b.lo[a] = odd_value();
				b.hi[a] = odd_value();
			end
		end
		return b;
	endfunction

	function automatic box_t make_box(input logic [31:0] lx, input logic [31:0] ly,
			input logic [31:0] lz, input logic [31:0] hx, input logic [31:0] hy,
			input logic [31:0] hz);
		box_t b;
		b.lo[0] = lx; b.lo[1] = ly; b.lo[2] = lz;
		b.hi[0] = hx; b.hi[1] = hy; b.hi[2] = hz;
		return b;
	endfunction

	// register writes, only while the pipe is empty
	task automatic write_ray(input logic [31:0] v [8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			ray_reg[i] = v[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every box has gone in and every result has come back
	task automatic drain();
		while (boxes_pending.size() != 0 || box_valid || hits_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// driver: a held transaction stays put while stalled
	always @(posedge clk or negedge arst_n) begin
		box_t b;
		if (!arst_n) begin
			box_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (box_valid && !box_stall) begin
				b = make_box(box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z);
				hits_expected.push_back(slab_intersect(b));
			end
			if (box_valid && box_stall) begin
				// hold
			end else if (send_gap > 0) begin
				send_gap--;
				box_valid <= 1'b0;
			end else if (boxes_pending.size() != 0) begin
				b = boxes_pending.pop_front();
				box_min_x <= b.lo[0]; box_min_y <= b.lo[1]; box_min_z <= b.lo[2];
				box_max_x <= b.hi[0]; box_max_y <= b.hi[1]; box_max_z <= b.hi[2];
				box_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 7);
			end else begin
				box_valid <= 1'b0;
			end
		end
	end

	// monitor: random stall bursts, each result checked against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		slab_res_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_len = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (hits_expected.size() == 0) begin
					$display("%0t: result with nothing expected: hit %0b enter %h exit %h",
						$time, hit, t_enter, t_exit);
					errors++;
				end else begin
					e = hits_expected.pop_front();
					if (hit !== e.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
						errors++;
					end
					if (t_enter !== e.t_enter) begin
						$display("%0t: t_enter expected %h actual %h", $time, e.t_enter, t_enter);
						errors++;
					end
					if (t_exit !== e.t_exit) begin
						$display("%0t: t_exit expected %h actual %h", $time, e.t_exit, t_exit);
						errors++;
					end
				end
			end
			if (stall_len > 0) begin
				stall_len--;
				res_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_len = $urandom_range(0, 6);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// timeout, far beyond the slowest correct run
	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [31:0] ray [8];
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rbs_pkg::CFG_ORIGIN_X;
		cfg_data = rbs_pkg::FP_ZERO;
		box_valid = 1'b0;
		res_stall = 1'b0;
		box_min_x = rbs_pkg::FP_ZERO; box_min_y = rbs_pkg::FP_ZERO;
		box_min_z = rbs_pkg::FP_ZERO;
		box_max_x = rbs_pkg::FP_ZERO; box_max_y = rbs_pkg::FP_ZERO;
		box_max_z = rbs_pkg::FP_ZERO;
		// reset ray: origin 0, direction 1, interval [0, +inf]
		ray_reg[rbs_pkg::CFG_ORIGIN_X] = rbs_pkg::FP_ZERO;
		ray_reg[rbs_pkg::CFG_ORIGIN_Y] = rbs_pkg::FP_ZERO;
		ray_reg[rbs_pkg::CFG_ORIGIN_Z] = rbs_pkg::FP_ZERO;
		ray_reg[rbs_pkg::CFG_DIR_X] = rbs_pkg::FP_ONE;
		ray_reg[rbs_pkg::CFG_DIR_Y] = rbs_pkg::FP_ONE;
		ray_reg[rbs_pkg::CFG_DIR_Z] = rbs_pkg::FP_ONE;
		ray_reg[rbs_pkg::CFG_T_START] = rbs_pkg::FP_ZERO;
		ray_reg[rbs_pkg::CFG_T_LIMIT] = rbs_pkg::FP_INF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed boxes against the reset ray
		boxes_pending.push_back(make_box(32'hBF80_0000, 32'hBF80_0000, 32'hBF80_0000,
			rbs_pkg::FP_ONE, rbs_pkg::FP_ONE, rbs_pkg::FP_ONE)); // unit box around origin
		boxes_pending.push_back(make_box(32'hC000_0000, 32'hC000_0000, 32'hC000_0000,
			32'hBF80_0000, 32'hBF80_0000, 32'hBF80_0000)); // behind the ray, miss
		boxes_pending.push_back(make_box(32'h4000_0000, rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO,
			32'h4040_0000, rbs_pkg::FP_ONE, rbs_pkg::FP_ONE)); // ahead, touching faces
		boxes_pending.push_back(make_box(rbs_pkg::FP_ONE, rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO,
			rbs_pkg::FP_ZERO, rbs_pkg::FP_ONE, rbs_pkg::FP_ONE)); // inverted slab, swap
		boxes_pending.push_back(make_box(rbs_pkg::CANON_NAN, rbs_pkg::FP_ZERO,
			rbs_pkg::FP_ZERO, rbs_pkg::FP_ONE, rbs_pkg::FP_ONE,
			rbs_pkg::FP_ONE));                             // nan corner
		boxes_pending.push_back(make_box(rbs_pkg::FP_ZERO, FP_SNAN, rbs_pkg::FP_ZERO,
			rbs_pkg::FP_ONE, FP_SNAN | FP_SIGN, rbs_pkg::FP_ONE)); // signalling nan both ends
		boxes_pending.push_back(make_box(rbs_pkg::FP_INF | FP_SIGN,
			rbs_pkg::FP_INF | FP_SIGN, rbs_pkg::FP_INF | FP_SIGN,
			rbs_pkg::FP_INF, rbs_pkg::FP_INF, rbs_pkg::FP_INF)); // infinite box
		boxes_pending.push_back(make_box(FP_MAX | FP_SIGN, FP_MAX | FP_SIGN, FP_MAX | FP_SIGN,
			FP_MAX, FP_MAX, FP_MAX));                      // largest finite box
		boxes_pending.push_back(make_box(FP_MINSUB | FP_SIGN, FP_MAXSUB | FP_SIGN, FP_SIGN,
			FP_MINSUB, FP_MAXSUB, rbs_pkg::FP_ZERO));      // subnormal and signed zero
		boxes_pending.push_back(make_box(rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO,
			rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO, rbs_pkg::FP_ZERO)); // degenerate point
		boxes_pending.push_back(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // all ones
		boxes_pending.push_back(make_box(32'h5000_0000, 32'h5000_0000, 32'h5000_0000,
			FP_MAX, FP_MAX, FP_MAX));                      // far box, large times
		drain();

		// each phase rewrites every register, then sends a batch of boxes
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				1: begin
					// zero directions of both signs, tiny direction, open interval
					ray[rbs_pkg::CFG_ORIGIN_X] = real_to_sp(rand_real(3));
					ray[rbs_pkg::CFG_ORIGIN_Y] = FP_MAX;
					ray[rbs_pkg::CFG_ORIGIN_Z] = FP_SIGN;
					ray[rbs_pkg::CFG_DIR_X] = rbs_pkg::FP_ZERO;
					ray[rbs_pkg::CFG_DIR_Y] = FP_SIGN;
					ray[rbs_pkg::CFG_DIR_Z] = FP_MINSUB;
					ray[rbs_pkg::CFG_T_START] = rbs_pkg::FP_INF | FP_SIGN;
					ray[rbs_pkg::CFG_T_LIMIT] = rbs_pkg::FP_INF;
				end
				2: begin
					// nan direction and nan interval ends
					ray[rbs_pkg::CFG_ORIGIN_X] = rbs_pkg::FP_ZERO;
					ray[rbs_pkg::CFG_ORIGIN_Y] = rbs_pkg::FP_ZERO;
					ray[rbs_pkg::CFG_ORIGIN_Z] = rbs_pkg::CANON_NAN;
					ray[rbs_pkg::CFG_DIR_X] = FP_SNAN;
					ray[rbs_pkg::CFG_DIR_Y] = rbs_pkg::FP_ONE;
					ray[rbs_pkg::CFG_DIR_Z] = FP_MAX | FP_SIGN;
					ray[rbs_pkg::CFG_T_START] = rbs_pkg::CANON_NAN;
					ray[rbs_pkg::CFG_T_LIMIT] = 32'hFFFF_FFFF;
				end
				3: begin
					// all-zero and all-one register patterns
					for (int i = 0; i < 8; i++) ray[i] = (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
					ray[rbs_pkg::CFG_DIR_X] = 32'hFFFF_FFFF;
					ray[rbs_pkg::CFG_T_START] = FP_MAX | FP_SIGN;
					ray[rbs_pkg::CFG_T_LIMIT] = FP_MAX;
				end
				4: begin
					for (int i = 0; i < 8; i++) ray[i] = $urandom;
				end
				default: begin
					// ordinary random ray with a finite or +inf interval end
					for (int a = 0; a < 3; a++) begin
						ray[rbs_pkg::CFG_ORIGIN_X + a] = real_to_sp(rand_real(8));
						ray[rbs_pkg::CFG_DIR_X + a] = ($urandom_range(0, 7) == 0) ?
							rbs_pkg::FP_ZERO : real_to_sp(rand_real(2));
					end
					ray[rbs_pkg::CFG_T_START] = real_to_sp(rand_real(1));
					ray[rbs_pkg::CFG_T_LIMIT] = ($urandom_range(0, 1)) ? rbs_pkg::FP_INF :
						real_to_sp(real'($urandom_range(1, 50000)) / 1000.0);
				end
			endcase
			// no idling on either side in the closing phase
			if (p == N_PHASES - 1) quiet = 1'b1;
			write_ray(ray);
			for (int n = 0; n < BOXES_PHASE; n++) boxes_pending.push_back(random_box());
			// every phase ends by waiting until all boxes are in and all results are back
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
